>>> sv/ptl_pkg.sv
// Shared widths and constants of the paged translation block.
package ptl_pkg;

  // Logical address and the position of the page field within it.
  localparam int ADDR_W     = 16;
  localparam int PAGE_SHIFT = 6;
  localparam int PAGE_RAW_W = ADDR_W - PAGE_SHIFT;

  // Fixed widths of the transfer fields.
  localparam int PROC_IN_W   = 3;
  localparam int FRAME_OUT_W = 3;
  localparam int VPAGE_OUT_W = 4;

  // Width of the access counter and of the load stamps.
  localparam int TIME_W = 5;

endpackage

>>> sv/paged_translation_lru.sv
// Demand-paged address translation with replacement of the oldest loaded frame.
module paged_translation_lru_core
  import ptl_pkg::*;
#(
  parameter int PROCESS_COUNT     = 8,
  parameter int FRAME_COUNT       = 8,
  parameter int PAGES_PER_PROCESS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [PROC_IN_W-1:0]   in_process_number,
  input  logic [ADDR_W-1:0]      in_logical_address,
  output logic                   out_strobe,
  output logic                   out_hit,
  output logic [FRAME_OUT_W-1:0] out_frame,
  output logic                   out_evicted,
  output logic [FRAME_OUT_W-1:0] out_victim_process,
  output logic [VPAGE_OUT_W-1:0] out_victim_page
);

  // An access is taken when start is high and busy is low. The page table lives in a
  // synchronous memory of PROCESS_COUNT * PAGES_PER_PROCESS entries; after reset the
  // block sweeps it clear, one entry a cycle, and holds busy high until the sweep ends.
  // An access is then handled in steps, and the block takes no new access until it is
  // back in idle: one step forms the table index and reads the table, the next one
  // decides and, on an eviction, clears the victim's entry, and on a fault a last step
  // writes the new entry through the single write port. The result is shown for exactly
  // one cycle with out_strobe and must be taken then: the receiver cannot hold it off.

  localparam int ENTRIES = PROCESS_COUNT * PAGES_PER_PROCESS;
  localparam int IW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int PW      = (PROCESS_COUNT > 1) ? $clog2(PROCESS_COUNT) : 1;
  localparam int GW      = $clog2(PAGES_PER_PROCESS);
  localparam int FW      = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int CW      = $clog2(FRAME_COUNT + 1);
  localparam int EW      = FW + 1;
  localparam int LVLS    = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int NLEAF   = 1 << LVLS;

  // Reciprocal of the page count, exact for every raw page value.
  localparam int PAGE_SH = PAGE_RAW_W + GW;
  localparam int PAGE_MW = PAGE_RAW_W + 1;
  localparam int PROD_W  = PAGE_RAW_W + PAGE_MW;
  localparam logic [PAGE_MW-1:0] PAGE_RECIP =
    PAGE_MW'(((1 << PAGE_SH) + PAGES_PER_PROCESS - 1) / PAGES_PER_PROCESS);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC,
    ST_LOOK,
    ST_FILL
  } state_t;

  state_t                state_r;
  logic [IW-1:0]         clr_cnt_r;
  logic [TIME_W-1:0]     time_r;
  logic [CW-1:0]         fill_r;
  logic [TIME_W-1:0]     stamp_r [FRAME_COUNT];
  logic [PW-1:0]         owner_proc_r [FRAME_COUNT];
  logic [GW-1:0]         owner_page_r [FRAME_COUNT];

  logic [PW-1:0]         proc_r;
  logic [GW-1:0]         page_r;
  logic [IW-1:0]         idx_r;
  logic [FW-1:0]         vict_r;
  logic [FW-1:0]         frame_r;
  logic                  evict_r;
  logic [PW-1:0]         vproc_r;
  logic [GW-1:0]         vpage_r;

  logic [EW-1:0]         pt_mem [ENTRIES];
  logic [EW-1:0]         pt_rdata_r;
  logic                  pt_we;
  logic [IW-1:0]         pt_waddr;
  logic [EW-1:0]         pt_wdata;

  logic [PAGE_RAW_W-1:0] page_raw;
  logic [PROD_W-1:0]     page_prod;
  logic [PAGE_RAW_W-1:0] page_quo;
  logic [PAGE_RAW_W-1:0] page_rem;
  logic [PW-1:0]         proc_nxt;
  logic [GW-1:0]         page_nxt;
  logic [IW-1:0]         idx_nxt;
  logic [TIME_W-1:0]     time_nxt;
  logic                  wrap;
  logic                  present;
  logic                  full;
  logic [FW-1:0]         frame_nxt;
  logic [IW-1:0]         vidx;

  logic [TIME_W-1:0]     tr_stamp [LVLS+1][NLEAF];
  logic [FW-1:0]         tr_idx   [LVLS+1][NLEAF];

  assign busy = (state_r != ST_IDLE);

  // Process and page of the incoming access reduced into range: the process through a
  // small constant table, the page by reciprocal multiplication.
  always_comb begin
    proc_nxt = '0;
    for (int v = 0; v < (1 << PROC_IN_W); v++) begin
      if (in_process_number == PROC_IN_W'(v)) begin
        proc_nxt = PW'(v % PROCESS_COUNT);
      end
    end
    page_raw  = in_logical_address[ADDR_W-1:PAGE_SHIFT];
    page_prod = PROD_W'(page_raw) * PROD_W'(PAGE_RECIP);
    page_quo  = PAGE_RAW_W'(page_prod >> PAGE_SH);
    page_rem  = page_raw - PAGE_RAW_W'(page_quo * PAGE_RAW_W'(PAGES_PER_PROCESS));
    page_nxt  = GW'(page_rem);
  end

  // Table index of the access.
  always_comb begin
    idx_nxt = IW'(int'(proc_r) * PAGES_PER_PROCESS + int'(page_r));
  end

  // Oldest frame: stamps never run ahead of the counter, so the smallest stamp has the
  // largest age. Ties go to the lower index, which always sits on the left.
  always_comb begin
    for (int lv = 0; lv <= LVLS; lv++) begin
      for (int i = 0; i < NLEAF; i++) begin
        tr_stamp[lv][i] = '1;
        tr_idx[lv][i]   = '0;
      end
    end
    for (int i = 0; i < FRAME_COUNT; i++) begin
      tr_stamp[0][i] = stamp_r[i];
      tr_idx[0][i]   = FW'(i);
    end
    for (int lv = 0; lv < LVLS; lv++) begin
      for (int i = 0; i < (NLEAF >> (lv + 1)); i++) begin
        if (tr_stamp[lv][2*i] <= tr_stamp[lv][2*i+1]) begin
          tr_stamp[lv+1][i] = tr_stamp[lv][2*i];
          tr_idx[lv+1][i]   = tr_idx[lv][2*i];
        end else begin
          tr_stamp[lv+1][i] = tr_stamp[lv][2*i+1];
          tr_idx[lv+1][i]   = tr_idx[lv][2*i+1];
        end
      end
    end
  end

  // Fault handling: a free frame while the fill count is short, else the oldest one.
  always_comb begin
    present   = pt_rdata_r[FW];
    full      = (fill_r == CW'(FRAME_COUNT));
    frame_nxt = full ? vict_r : FW'(fill_r);
    vidx      = IW'(int'(owner_proc_r[vict_r]) * PAGES_PER_PROCESS
                    + int'(owner_page_r[vict_r]));
    time_nxt  = time_r + TIME_W'(1);
    wrap      = (time_nxt == '0);
  end

  // Single write port of the page table.
  always_comb begin
    pt_we    = 1'b0;
    pt_waddr = clr_cnt_r;
    pt_wdata = '0;
    case (state_r)
      ST_CLEAR: begin
        pt_we = 1'b1;
      end
      ST_LOOK: begin
        if (!present && full) begin
          pt_we    = 1'b1;
          pt_waddr = vidx;
        end
      end
      ST_FILL: begin
        pt_we    = 1'b1;
        pt_waddr = idx_r;
        pt_wdata = {1'b1, frame_r};
      end
      default: begin
        pt_we = 1'b0;
      end
    endcase
  end

  // Page table memory with registered read data.
  always_ff @(posedge clk) begin
    if (pt_we) begin
      pt_mem[pt_waddr] <= pt_wdata;
    end
    if (state_r == ST_CALC) begin
      pt_rdata_r <= pt_mem[idx_nxt];
    end
  end

  // Sequencer, frame bookkeeping and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_cnt_r  <= '0;
      time_r     <= '0;
      fill_r     <= '0;
      out_strobe <= 1'b0;
      for (int f = 0; f < FRAME_COUNT; f++) begin
        stamp_r[f] <= '0;
      end
    end else begin
      out_strobe <= 1'b0;
      case (state_r)
        ST_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + IW'(1);
          if (clr_cnt_r == IW'(ENTRIES - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            proc_r  <= proc_nxt;
            page_r  <= page_nxt;
            state_r <= ST_CALC;
          end
        end
        ST_CALC: begin
          idx_r   <= idx_nxt;
          vict_r  <= tr_idx[LVLS][0];
          state_r <= ST_LOOK;
        end
        ST_LOOK: begin
          if (present) begin
            out_strobe         <= 1'b1;
            out_hit            <= 1'b1;
            out_frame          <= FRAME_OUT_W'(pt_rdata_r[FW-1:0]);
            out_evicted        <= 1'b0;
            out_victim_process <= '0;
            out_victim_page    <= '0;
            time_r             <= time_nxt;
            if (wrap) begin
              for (int f = 0; f < FRAME_COUNT; f++) begin
                stamp_r[f] <= '0;
              end
            end
            state_r <= ST_IDLE;
          end else begin
            frame_r <= frame_nxt;
            evict_r <= full;
            vproc_r <= owner_proc_r[vict_r];
            vpage_r <= owner_page_r[vict_r];
            state_r <= ST_FILL;
          end
        end
        ST_FILL: begin
          owner_proc_r[frame_r] <= proc_r;
          owner_page_r[frame_r] <= page_r;
          for (int f = 0; f < FRAME_COUNT; f++) begin
            if (wrap) begin
              stamp_r[f] <= '0;
            end else if (frame_r == FW'(f)) begin
              stamp_r[f] <= time_r;
            end
          end
          if (!evict_r) begin
            fill_r <= fill_r + CW'(1);
          end
          time_r             <= time_nxt;
          out_strobe         <= 1'b1;
          out_hit            <= 1'b0;
          out_frame          <= FRAME_OUT_W'(frame_r);
          out_evicted        <= evict_r;
          out_victim_process <= evict_r ? FRAME_OUT_W'(vproc_r) : '0;
          out_victim_page    <= evict_r ? VPAGE_OUT_W'(vpage_r) : '0;
          state_r            <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
